@@ rtl/keyed_table_with_running_sum_unit_assert.svh @@
// Assertion macros for the keyed table with running sum.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef KEYED_TABLE_WITH_RUNNING_SUM_UNIT_ASSERT_SVH
`define KEYED_TABLE_WITH_RUNNING_SUM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define KTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression never holds outside reset.
`define KTS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KTS_ASSERT(lbl, prop, msg)
`define KTS_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/kts_pkg.sv @@
// Shared types and constants for the keyed table with running sum.
// No dependencies.
package kts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = KEY_W + VAL_W;
  localparam int SUM_W       = 42;
  localparam int ENTRIES_W   = 11;

  localparam logic KIND_UPSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [SUM_W-1:0]       total;
    logic [ENTRIES_W-1:0]   entries;
  } result_t;

  // Sign-extend a stored value to the width of the running sum.
  function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

@@ rtl/kts_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/kts_ctrl.sv @@
// Sequencer for the keyed table: linear search, update or append, and shift-down on remove.
// Depends on kts_pkg and the assertion macro header; drives the entry RAM ports.
`include "keyed_table_with_running_sum_unit_assert.svh"
module kts_ctrl import kts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  output logic                res_valid,
  input  logic                res_take,
  output result_t             res,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output logic [ENTRY_W-1:0]  mem_wdata,
  output logic                mem_re,
  output logic [IDX_W-1:0]    mem_raddr,
  input  logic [ENTRY_W-1:0]  mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             kind_r, kind_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;

  logic             in_acc;
  logic             issue;
  logic             hit;
  logic             last;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign rd_key  = mem_rdata[ENTRY_W-1:VAL_W];
  assign rd_val  = mem_rdata[VAL_W-1:0];
  assign issue   = (iss_r < count_r);
  assign hit     = pend_r && (rd_key == key_r);
  assign last    = pend_r && (CNT_W'(pidx_r) == count_r - CNT_W'(1));

  assign res_valid   = (state_r == S_DONE);
  assign res.status  = status_r;
  assign res.total   = sum_r;
  assign res.entries = ENTRIES_W'(count_r);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    iss_nxt    = iss_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    mem_re     = 1'b0;
    mem_raddr  = iss_r[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = count_r[IDX_W-1:0];
    mem_wdata  = {key_r, val_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_kind;
          key_nxt  = in_key;
          val_nxt  = in_value;
          iss_nxt  = '0;
          if (in_kind == KIND_UPSERT && count_r == CNT_W'(TABLE_DEPTH)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // one read per cycle; compare lands in the cycle after the read
        mem_re   = issue;
        pend_nxt = issue;
        pidx_nxt = iss_r[IDX_W-1:0];
        iss_nxt  = issue ? iss_r + CNT_W'(1) : iss_r;
        if (hit) begin
          pend_nxt = 1'b0;
          if (kind_r == KIND_UPSERT) begin
            mem_we     = 1'b1;
            mem_waddr  = pidx_r;
            sum_nxt    = sum_r - sext_val(rd_val) + sext_val(val_r);
            status_nxt = ST_UPDATED;
            state_nxt  = S_DONE;
          end else begin
            sum_nxt = sum_r - sext_val(rd_val);
            if (last) begin
              count_nxt  = count_r - CNT_W'(1);
              status_nxt = ST_REMOVED;
              state_nxt  = S_DONE;
            end else begin
              // close the gap: read from the slot above the hit
              iss_nxt   = CNT_W'(pidx_r) + CNT_W'(1);
              state_nxt = S_SHIFT;
            end
          end
        end else if (count_r == '0 || last) begin
          pend_nxt = 1'b0;
          if (kind_r == KIND_UPSERT) begin
            mem_we     = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
            sum_nxt    = sum_r + sext_val(val_r);
            status_nxt = ST_ADDED;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        mem_re   = issue;
        pend_nxt = issue;
        pidx_nxt = iss_r[IDX_W-1:0];
        iss_nxt  = issue ? iss_r + CNT_W'(1) : iss_r;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r - IDX_W'(1);
          mem_wdata = mem_rdata;
          if (last) begin
            pend_nxt   = 1'b0;
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = ST_REMOVED;
            state_nxt  = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
    end
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    iss_r    <= iss_nxt;
    pidx_r   <= pidx_nxt;
  end

  `KTS_ASSERT(a_full_reject, (in_acc && in_kind == KIND_UPSERT && count_r == CNT_W'(TABLE_DEPTH)) |=> (state_r == S_DONE && status_r == ST_FULL && $stable(count_r)), "full table upsert not rejected")
  `KTS_ASSERT(a_count_moves_at_end, !$stable(count_r) |-> (state_r == S_DONE), "entry count changed outside completion")
  `KTS_NEVER(a_write_beyond_count, mem_we && (CNT_W'(mem_waddr) >= count_r) && !(state_r == S_SEARCH && kind_r == KIND_UPSERT && CNT_W'(mem_waddr) == count_r), "RAM write past the valid entries")

endmodule

@@ rtl/keyed_table_with_running_sum_unit.sv @@
// Top level of the keyed table with running sum: entry RAM, sequencer and output register.
// Depends on kts_pkg, kts_ram and kts_ctrl.
//
// Usage:
//  Input channel (in_valid / in_stall, in_kind, in_key, in_value) carries one
//  operation per transfer: kind 0 adds or updates the entry for in_key, kind 1
//  removes it. Output channel (out_valid / out_stall) returns one result per
//  operation: status, running total of stored values, and entry count.
//  Entries live in one RAM of key/value pairs, read one per cycle during the
//  search; the search stops at the match, and on a remove the slots above it
//  then shift down one per cycle. A full-table upsert is rejected without a
//  search. The result sits in an output register; a new operation is taken
//  as soon as the sequencer is idle, even while that result waits. When the
//  receiver stalls with a result held, the next operation runs to completion
//  and then waits. Reset clears the entry count and the total; the RAM needs
//  no clearing since only slots below the count are ever read.
module keyed_table_with_running_sum_unit import kts_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic signed [KEY_W-1:0]     in_key,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic signed [SUM_W-1:0]     out_total,
  output logic [ENTRIES_W-1:0]        out_entries
);

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  logic                 res_valid;
  logic                 res_take;
  result_t              res;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [SUM_W-1:0]     out_total_r;
  logic [ENTRIES_W-1:0] out_entries_r;

  kts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_key    (in_key),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // load the output register when it is empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_status_r  <= res.status;
      out_total_r   <= res.total;
      out_entries_r <= res.entries;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_total   = out_total_r;
  assign out_entries = out_entries_r;

endmodule

@@ sim/tb.sv @@
// Self-checking bench for keyed_table_with_running_sum_unit: upsert/remove traffic, a
// mirror of the table that predicts each result, and a comparison of every result.
// Depends on kts_pkg and the RTL of the unit only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kts_pkg::*;

  localparam logic [KEY_W-1:0] INT_MIN    = 32'h8000_0000;
  localparam logic [KEY_W-1:0] INT_MAX    = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [KEY_W-1:0] FILL_BASE  = 32'h3000_0000;
  localparam int               POOL_SIZE  = 16;
  localparam int               RANDOM_OPS = 450;
  localparam int               HOLD_AFTER = 150;
  localparam int               HOLD_LEN   = 400;

  // Mirror of the entry table: slots in insertion order, plus the running total.
  class keyed_table_mirror;
    logic [KEY_W-1:0] keys[$];
    logic [VAL_W-1:0] vals[$];
    logic [SUM_W-1:0] total;
    result_t          pending_results[$];
    int               errors;
    int               checked;
    int               peak;
    int               by_status[5];

    function new();
      total   = '0;
      errors  = 0;
      checked = 0;
      peak    = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function int size();
      return keys.size();
    endfunction

    function logic [KEY_W-1:0] key_at(int slot);
      return keys[slot];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [SUM_W-1:0] widen(logic [VAL_W-1:0] v);
      logic signed [SUM_W-1:0] w;
      w = $signed(v);
      return w;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      foreach (keys[i]) if (keys[i] == k) return i;
      return -1;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void apply_op(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      result_t r;
      int      slot;
      slot = find_key(key);
      if (kind == KIND_UPSERT) begin
        // a full table rejects even a key it already holds
        if (keys.size() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (slot >= 0) begin
          total = total - widen(vals[slot]) + widen(value);
          vals[slot] = value;
          r.status = ST_UPDATED;
        end else begin
          keys.push_back(key);
          vals.push_back(value);
          total = total + widen(value);
          r.status = ST_ADDED;
        end
      end else if (slot < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        total = total - widen(vals[slot]);
        keys.delete(slot);
        vals.delete(slot);
        r.status = ST_REMOVED;
      end
      r.total   = total;
      r.entries = ENTRIES_W'(keys.size());
      by_status[r.status]++;
      if (keys.size() > peak) peak = keys.size();
      pending_results.push_back(r);
    endfunction

    function void compare_result(logic [2:0] status, logic [SUM_W-1:0] sum,
                                 logic [ENTRIES_W-1:0] entries);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result %0d: status %0d total %0d entries %0d",
                             checked, status, $signed(sum), entries));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        flag_error($sformatf("result %0d status: expected %0d (%s), got %0d",
                             checked, want.status, want.status.name(), status));
      if (sum !== want.total)
        flag_error($sformatf("result %0d total: expected %0d, got %0d",
                             checked, $signed(want.total), $signed(sum)));
      if (entries !== want.entries)
        flag_error($sformatf("result %0d entries: expected %0d, got %0d",
                             checked, want.entries, entries));
    endfunction

    function void close_out();
      if (pending_results.size() != 0)
        flag_error($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        in_kind     = KIND_UPSERT;
  logic signed [KEY_W-1:0]     in_key      = '0;
  logic signed [VAL_W-1:0]     in_value    = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [2:0]                  out_status;
  logic signed [SUM_W-1:0]     out_total;
  logic [ENTRIES_W-1:0]        out_entries;

  keyed_table_mirror mirror;
  logic [KEY_W-1:0]  key_pool[POOL_SIZE];
  int                burst_left = 0;
  int                rx_mode    = 0;
  int                rx_left    = 0;
  int                hold_left  = 0;
  bit                hold_done  = 1'b0;

  keyed_table_with_running_sum_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_total   (out_total),
    .out_entries (out_entries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      mirror.compare_result(out_status, out_total, out_entries);
    if (!hold_done && mirror.checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      // hold off long enough for the unit to back up into its input
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_left[2];
      endcase
    end
  end

  // Offer one operation and hold it until the unit takes it.
  task automatic push_op(input logic kind, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
    int gap;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.apply_op(kind, key, value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_op();
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    int               pick;
    // lean toward removes once the table grows, to keep searches short
    if (mirror.size() > 40) kind = ($urandom_range(0, 9) < 7) ? KIND_REMOVE : KIND_UPSERT;
    else kind = ($urandom_range(0, 99) < 45) ? KIND_REMOVE : KIND_UPSERT;
    pick = $urandom_range(0, 9);
    if (pick == 0) value = INT_MIN;
    else if (pick == 1) value = INT_MAX;
    else if (pick == 2) value = $urandom_range(0, 16) - 8;
    else value = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40 && mirror.size() > 0) key = mirror.key_at($urandom_range(0, mirror.size() - 1));
    else if (pick < 75) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = $urandom;
    push_op(kind, key, value);
  endtask

  initial begin
    int idx;
    mirror = new();
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = 32'd1;
    key_pool[3] = INT_MIN;
    key_pool[4] = INT_MAX;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes of key and value, first/middle/last removal
    push_op(KIND_REMOVE, '0, '0);
    push_op(KIND_UPSERT, INT_MIN, INT_MIN);
    push_op(KIND_UPSERT, INT_MAX, INT_MAX);
    push_op(KIND_UPSERT, '0, '0);
    push_op(KIND_UPSERT, ALL_ONES, ALL_ONES);
    push_op(KIND_UPSERT, INT_MIN, INT_MAX);
    push_op(KIND_UPSERT, '0, INT_MIN);
    push_op(KIND_REMOVE, 32'd12345, ALL_ONES);
    push_op(KIND_REMOVE, INT_MAX, INT_MAX);
    push_op(KIND_REMOVE, INT_MIN, '0);
    push_op(KIND_REMOVE, ALL_ONES, '0);
    push_op(KIND_REMOVE, ALL_ONES, '0);
    push_op(KIND_UPSERT, 32'h5555_5555, 32'haaaa_aaaa);
    push_op(KIND_UPSERT, 32'haaaa_aaaa, 32'h5555_5555);
    push_op(KIND_REMOVE, '0, '0);
    push_op(KIND_REMOVE, 32'h5555_5555, '0);
    push_op(KIND_REMOVE, 32'haaaa_aaaa, '0);
    push_op(KIND_REMOVE, 32'haaaa_aaaa, '0);

    repeat (RANDOM_OPS) random_op();

    // empty the table, then fill it to the brim with the most negative value
    while (mirror.size() > 0)
      push_op(KIND_REMOVE, mirror.key_at($urandom_range(0, mirror.size() - 1)), $urandom);
    idx = 0;
    while (mirror.size() < TABLE_DEPTH) begin
      push_op(KIND_UPSERT, FILL_BASE + idx, INT_MIN);
      idx++;
    end
    push_op(KIND_UPSERT, FILL_BASE + 7, INT_MAX);
    push_op(KIND_UPSERT, 32'h1234_5678, '0);
    push_op(KIND_REMOVE, FILL_BASE + TABLE_DEPTH / 2, '0);
    push_op(KIND_UPSERT, FILL_BASE + TABLE_DEPTH / 2, INT_MAX);
    push_op(KIND_UPSERT, FILL_BASE + TABLE_DEPTH / 2, '0);
    push_op(KIND_REMOVE, FILL_BASE + TABLE_DEPTH / 2, '0);
    push_op(KIND_REMOVE, FILL_BASE + TABLE_DEPTH - 1, '0);
    push_op(KIND_REMOVE, FILL_BASE, '0);
    push_op(KIND_REMOVE, 32'h1234_5678, '0);
    push_op(KIND_UPSERT, FILL_BASE + 3, INT_MAX);
    in_valid <= 1'b0;

    while (mirror.pending() > 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
    mirror.close_out();

    $display("Covered %0d operations: %0d added, %0d updated, %0d removed, %0d full, %0d missing",
             mirror.checked, mirror.by_status[ST_ADDED], mirror.by_status[ST_UPDATED],
             mirror.by_status[ST_REMOVED], mirror.by_status[ST_FULL],
             mirror.by_status[ST_NOTFOUND]);
    $display("Table reached %0d entries; %0d mismatches seen", mirror.peak, mirror.errors);
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout: %0d results still outstanding", mirror.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
